FILE: hdl/ddr_pkg.sv
package ddr_pkg;
    localparam int unsigned QBITS = 54;
    localparam int unsigned MBITS = 53;

    typedef struct packed {
        logic        bzero;
        logic        azero;
        logic        sign;
        logic [12:0] exp;
        logic [54:0] rem;
        logic [52:0] mb;
        logic [53:0] q;
    } div_stage_t;
endpackage

FILE: hdl/ddr_if.sv
interface ddr_if #(
    parameter int unsigned W = 128
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ddr_pre.sv
module ddr_pre (
    input  logic [63:0]        dividend,
    input  logic [63:0]        divisor,
    output ddr_pkg::div_stage_t st
);
    logic [52:0] ma;
    logic [52:0] mb;
    logic        lt;
    logic [12:0] e0;

    always_comb
    begin
        ma = {1'b1, dividend[51:0]};
        mb = {1'b1, divisor[51:0]};
        lt = (ma < mb);
        e0 = 13'({2'b00, dividend[62:52]}) - 13'({2'b00, divisor[62:52]}) + 13'd1022
             - (lt ? 13'd1 : 13'd0);
        st.bzero = (divisor[62:0] == 63'd0);
        st.azero = (dividend[62:0] == 63'd0);
        st.sign  = dividend[63] ^ divisor[63];
        st.exp   = e0;
        st.rem   = lt ? {1'b0, ma, 1'b0} : {2'b00, ma};
        st.mb    = mb;
        st.q     = '0;
    end
endmodule

FILE: hdl/ddr_step.sv
// One restoring step: compare, subtract, shift, set one quotient bit.
module ddr_step (
    input  ddr_pkg::div_stage_t st_in,
    input  logic [5:0]          bitpos,
    output ddr_pkg::div_stage_t st_out
);
    logic        ge;
    logic [54:0] diff;

    always_comb
    begin
        ge   = (st_in.rem >= {2'b00, st_in.mb});
        diff = ge ? st_in.rem - {2'b00, st_in.mb} : st_in.rem;
        st_out     = st_in;
        st_out.rem = {diff[53:0], 1'b0};
        st_out.q   = st_in.q | (ge ? (54'd1 << bitpos) : 54'd0);
    end
endmodule

FILE: hdl/ddr_post.sv
module ddr_post (
    input  ddr_pkg::div_stage_t st,
    output logic [63:0]         quotient,
    output logic                overflow
);
    logic [63:0] q;
    logic [12:0] e;
    logic [12:0] n;
    logic [63:0] sgn;

    always_comb
    begin
        sgn = {st.sign, 63'd0};
        e = st.exp;
        n = 13'd0 - st.exp;
        q = {10'd0, st.q};
        overflow = 1'b0;
        if (!e[12])
        begin
            q = (q + 64'd1) >> 1;
            e = e + 13'd1;
        end
        else
        begin
            e = 13'd0;
            if (n <= 13'd53)
                q = (q + (64'd1 << n[5:0])) >> (n[5:0] + 6'd1);
            else
                q = 64'd0;
        end
        q[52] = 1'b0;
        if (st.bzero)
            quotient = st.sign ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
        else if (st.azero)
            quotient = sgn;
        else if (!e[12] && e >= 13'd2047)
        begin
            overflow = 1'b1;
            quotient = sgn | 64'h7FF0_0000_0000_0000;
        end
        else
            quotient = sgn | ({51'd0, e} << 52) | q;
    end
endmodule

FILE: hdl/double_divide_restoring.sv
// Pipelined double divider: one divide may enter every cycle unless the pipe
// is stalled. From the accepting edge to out valid a divide passes an
// operand-unpack register, 54 restoring-division stages (one quotient bit
// each), a hand-off register and the rounding/pack register. A stall freezes
// the pipe in place; results hold on the output until taken.
module double_divide_restoring (
    input  logic   clk,
    input  logic   rst_n,
    ddr_if.sink    in_ch,
    ddr_if.source  out_ch
);
    localparam int unsigned NS = ddr_pkg::QBITS + 2;

    ddr_pkg::div_stage_t st_reg [NS];
    ddr_pkg::div_stage_t st_next [NS];
    logic [NS-1:0] vld_reg;
    logic [63:0]   q_reg;
    logic          ovf_reg;
    logic [63:0]   q_next;
    logic          ovf_next;
    logic          adv;

    // whole pipe moves when the output slot is free or being drained
    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    ddr_pre u_pre (
        .dividend (in_ch.data[127:64]),
        .divisor  (in_ch.data[63:0]),
        .st       (st_next[0])
    );

    for (genvar i = 0; i < ddr_pkg::QBITS; i++)
    begin : g_step
        ddr_step u_step (
            .st_in  (st_reg[i]),
            .bitpos (6'(ddr_pkg::QBITS - 1 - i)),
            .st_out (st_next[i+1])
        );
    end

    assign st_next[NS-1] = st_reg[NS-2];

    ddr_post u_post (
        .st       (st_reg[NS-1]),
        .quotient (q_next),
        .overflow (ovf_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], in_ch.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NS; i++)
                st_reg[i] <= st_next[i];
            q_reg   <= q_next;
            ovf_reg <= ovf_next;
        end
    end

    logic outv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outv_reg <= 1'b0;
        else if (adv)
            outv_reg <= vld_reg[NS-1];
    end

    assign out_ch.valid = outv_reg;
    assign out_ch.data  = {q_reg, ovf_reg};

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg)) else $error("pipe moved during stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == adv) else $error("ready mismatch");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_ch.valid == $past(vld_reg[NS-1])) else $error("beat lost");
endmodule

FILE: tb/ddr_checker.sv
`timescale 1ns / 100ps

module ddr_checker (
    input  logic   clk,
    input  logic   rst_n,
    ddr_if.sink    in_mon,
    ddr_if.sink    out_mon,
    output int     fail_count,
    output int     pending_count,
    output int     result_count
);
    typedef struct packed {
        logic [63:0] quotient;
        logic        overflow;
    } div_result_t;

    div_result_t expected_quotients[$];

    function automatic div_result_t predict_divide(logic [63:0] a, logic [63:0] b);
        div_result_t r;
        logic        sgn;
        int          e;
        int          n;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        r.overflow = 1'b0;
        sgn = a[63] ^ b[63];
        e = int'(a[62:52]) - int'(b[62:52]) + 1022;
        if (b[62:0] == '0)
            r.quotient = sgn ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
        else if (a[62:0] == '0)
            r.quotient = {sgn, 63'd0};
        else
        begin
            ma = {11'd0, 1'b1, a[51:0]};
            mb = {11'd0, 1'b1, b[51:0]};
            if (ma < mb)
            begin
                ma = ma << 1;
                e = e - 1;
            end
            q = '0;
            for (int i = 53; i >= 0; i--)
            begin
                if (ma >= mb)
                begin
                    q[i] = 1'b1;
                    ma = ma - mb;
                end
                ma = ma << 1;
            end
            if (e >= 0)
            begin
                q = (q + 64'd1) >> 1;
                e = e + 1;
            end
            else
            begin
                n = -e;
                e = 0;
                if (n <= 53)
                    q = (q + (64'd1 << n)) >> (n + 1);
                else
                    q = '0;
            end
            q[52] = 1'b0;
            if (e >= 2047)
            begin
                r.overflow = 1'b1;
                r.quotient = sgn ? 64'hFFF0_0000_0000_0000 : 64'h7FF0_0000_0000_0000;
            end
            else
                r.quotient = {sgn, 63'd0} | (64'(e) << 52) | q;
        end
        return r;
    endfunction

    assign pending_count = expected_quotients.size();

    always @(posedge clk or negedge rst_n)
    begin
        div_result_t want;
        div_result_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
            result_count <= 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                expected_quotients.push_back(
                    predict_divide(in_mon.data[127:64], in_mon.data[63:0]));
            if (out_mon.valid && out_mon.ready)
            begin
                got.quotient = out_mon.data[64:1];
                got.overflow = out_mon.data[0];
                result_count <= result_count + 1;
                if (expected_quotients.size() == 0)
                begin
                    $display("%0t: unexpected result q=%h ovf=%b", $time,
                             got.quotient, got.overflow);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_quotients.pop_front();
                    if (want.quotient !== got.quotient || want.overflow !== got.overflow)
                    begin
                        $display("%0t: mismatch expected q=%h ovf=%b, actual q=%h ovf=%b",
                                 $time, want.quotient, want.overflow,
                                 got.quotient, got.overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    localparam int PIPE_LATENCY = 56;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   result_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   recv_hold;
    int   beats_sent;

    ddr_if #(.W(128)) in_ch ();
    ddr_if #(.W(65)) out_ch ();

    double_divide_restoring uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    ddr_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_ch.sink),
        .out_mon       (out_ch.sink),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when asked
    always @(negedge clk)
        out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        logic [10:0] ex;
        v = {$urandom, $urandom};
        ex = v[62:52];
        case ($urandom_range(9))
            0: ex = 11'd0;
            1: ex = 11'h7FF;
            2: ex = 11'($urandom_range(1, 40));
            3: ex = 11'($urandom_range(2000, 2046));
            4: v[51:0] = $urandom_range(1) ? '1 : '0;
            default: ex = 11'($urandom_range(900, 1150));
        endcase
        if ($urandom_range(9) != 4)
            v[62:52] = ex;
        if ($urandom_range(29) == 0)
            v[62:0] = '0;
        return v;
    endfunction

    task automatic send_beat(logic [63:0] a, logic [63:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {a, b};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        int waited;
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_count != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_beat(rand_double(), rand_double());
    endtask

    initial
    begin
        logic [63:0] dir_a[$];
        logic [63:0] dir_b[$];
        rst_n = 1'b0;
        cycle_count = 0;
        recv_hold = 1'b0;
        beats_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero divisors, zero dividends, overflow, deep denormal, all-ones fields
        dir_a = '{64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h0,
                  64'h8000_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                  64'h0010_0000_0000_0000, 64'h0000_0000_0000_0001,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h4008_0000_0000_0000,
                  64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                  64'h001F_FFFF_FFFF_FFFF, 64'h3FFF_FFFF_FFFF_FFFF,
                  64'h0030_0000_0000_0000, 64'h4000_0000_0000_0000};
        dir_b = '{64'h0, 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000,
                  64'hC000_0000_0000_0000, 64'h0010_0000_0000_0000,
                  64'h7FEF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h3FF8_0000_0000_0000,
                  64'h3FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                  64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0001,
                  64'h4330_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF};
        foreach (dir_a[i])
            send_beat(dir_a[i], dir_b[i]);
        drain();

        send_idle_pct = 37;
        recv_idle_pct = 88;
        random_phase(160);
        drain();

        send_idle_pct = 88;
        recv_idle_pct = 37;
        random_phase(90);
        drain();

        // long receiver hold-off so the pipe backs up into the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(negedge clk);
                recv_hold = 1'b0;
            end
            random_phase(100);
        join
        random_phase(150);
        drain();

        $display("Sent %0d divide beats, checked %0d results (zeros, overflow, denormals,",
                 beats_sent, result_count);
        $display("random operands) under mixed and heavy back-pressure.");
        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: sim.f
hdl/ddr_pkg.sv
hdl/ddr_if.sv
hdl/ddr_pre.sv
hdl/ddr_step.sv
hdl/ddr_post.sv
hdl/double_divide_restoring.sv
tb/ddr_checker.sv
tb/testbench.sv
